>>> src/ppg_pkg.sv
// Package for the plasma pixel generator: widths, register indexes and the
// sine ROM contents. It depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ppg_pkg;

    // Coordinate, phase and result widths.
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int P1_W    = 9;
    localparam int P2_W    = 9;
    localparam int P3_W    = 10;
    localparam int INDEX_W = 8;
    localparam int COLOR_W = 16;

    // Nominal scan size; coordinates outside it are not clipped.
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;

    // Sine ROM geometry. Addresses wrap modulo the depth.
    localparam int SINE_DEPTH = 2048;
    localparam int ADDR_W     = $clog2(SINE_DEPTH);
    localparam int SINE_W     = 8;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_DATA_W = ((X_W + Y_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((INDEX_W + COLOR_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_ONE   = 2'd0,
        CFG_PHASE_TWO   = 2'd1,
        CFG_PHASE_THREE = 2'd2
    } cfg_index_t;

    localparam logic [P1_W-1:0] PHASE_ONE_RESET   = 9'd132;
    localparam logic [P2_W-1:0] PHASE_TWO_RESET   = 9'd248;
    localparam logic [P3_W-1:0] PHASE_THREE_RESET = 10'd380;

    // Which of the three waveforms a ROM instance holds.
    typedef enum logic [1:0] {
        SINE_SEL_A,
        SINE_SEL_B,
        SINE_SEL_C
    } sine_sel_t;

    typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

    // Fixed-point constants: pi in Q60 and 2*pi in Q48.
    localparam logic [63:0] Q60_PI     = 64'h3243F6A8885A308D;
    localparam logic [63:0] Q48_TWO_PI = Q60_PI >> 11;
    localparam logic [63:0] LOW32      = 64'hFFFF_FFFF;

    // (a * b) >> 60 for operands below 2^62, built from 32-bit partial products.
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a0, a1, b0, b1;
        logic [63:0] p00, p01, p10, p11;
        logic [63:0] mid, lo, hi;
        a0  = a & LOW32;
        a1  = a >> 32;
        b0  = b & LOW32;
        b1  = b >> 32;
        p00 = a0 * b0;
        p01 = a0 * b1;
        p10 = a1 * b0;
        p11 = a1 * b1;
        mid = (p00 >> 32) + (p01 & LOW32) + (p10 & LOW32);
        lo  = (p00 & LOW32) | (mid << 32);
        hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
        return (hi << 4) | (lo >> 60);
    endfunction

    // Unsigned 64-bit quotient by shift and subtract, one bit per pass.
    // Used only while the ROM contents are built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int bit_idx = 63; bit_idx >= 0; bit_idx--) begin
            rem = {rem[63:0], num[bit_idx]};
            if (rem >= {1'b0, den}) begin
                rem          = rem - {1'b0, den};
                quo[bit_idx] = 1'b1;
            end
        end
        return quo;
    endfunction

    // floor(sin(n / div) * amp + amp), evaluated in fixed-point integer arithmetic with a Taylor series.
    function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] n,
                                                     input logic [63:0] div,
                                                     input logic [63:0] amp);
        logic [63:0] n48, period, r, ang, x2, term, sum, s56, prod, mag;
        logic        neg;
        n48    = n << 48;
        period = div * Q48_TWO_PI;
        r      = n48 - udiv64(n48, period) * period;
        ang    = udiv64(r, div) << 12;
        neg    = 1'b0;
        if (ang >= Q60_PI) begin
            neg = 1'b1;
            ang = ang - Q60_PI;
        end
        if (ang > (Q60_PI >> 1)) begin
            ang = Q60_PI - ang;
        end
        x2   = qmul(ang, ang);
        term = ang;
        sum  = ang;
        for (int i = 1; i <= 12; i++) begin
            term = udiv64(qmul(term, x2), 64'(2 * i) * 64'(2 * i + 1));
            if (i[0] == 1'b1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        s56  = sum >> 4;
        prod = amp * s56;
        if (!neg) begin
            mag = prod >> 56;
            if (mag > amp) begin
                mag = amp;
            end
            return SINE_W'(amp + mag);
        end
        mag = (prod + ((64'd1 << 56) - 64'd1)) >> 56;
        if (mag > amp) begin
            mag = amp;
        end
        return SINE_W'(amp - mag);
    endfunction

    function automatic sine_rom_t sine_table(input logic [63:0] div, input logic [63:0] amp);
        sine_rom_t t;
        for (int n = 0; n < SINE_DEPTH; n++) begin
            t[n] = sine_entry(64'(n), div, amp);
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_A = sine_table(64'd45, 64'd63);
    localparam sine_rom_t SINE_B = sine_table(64'd75, 64'd42);
    localparam sine_rom_t SINE_C = sine_table(64'd32, 64'd88);

endpackage

`default_nettype wire

>>> src/plasma_pixel_generator_core.sv
// Top level of the plasma pixel generator: config registers, ROM pipeline
// and output register. Depends on ppg_pkg, ppg_sine_rom and ppg_palette.
`timescale 1ns / 1ps
`default_nettype none

// The block turns a pixel position into a plasma color. An item on the s_
// stream carries pixel_x and pixel_y; the matching item on the m_ stream
// carries the plasma index (the wrapped sum of four sine lookups) and its
// RGB565 color. Items leave in the order they arrived, one result per item.
//
// An accepted item passes through three register stages before it shows up
// on m_tvalid. Throughput is one item per cycle while m_tready stays high.
// The stages are the first sine lookups (block ROM reads), the nested lookup
// whose address depends on a first-stage ROM word together with phase three
// and pixel_x, and the output register fed by the final add and the palette.
//
// The three phase registers are written through cfg_we/cfg_index/cfg_data and
// are meant to change between frames while no item is in flight. Writes to
// an index outside the list are ignored; wide data is truncated.
//
// Reset (aresetn low, synchronous) empties the pipeline and loads the phase
// registers with their defaults. When the receiver stalls, the whole pipeline
// holds in place, including the ROM output registers, and s_tready drops; no
// item is lost or repeated. s_tready is high whenever the output register is
// empty or is being emptied in the same cycle.
module plasma_pixel_generator_core
    import ppg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // pixel_x [9:0], pixel_y [18:10], zeros above

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,   // plasma_index [7:0], pixel_color [23:8]

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Phase registers.
    logic [P1_W-1:0] phase_one_reg;
    logic [P2_W-1:0] phase_two_reg;
    logic [P3_W-1:0] phase_three_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_one_reg   <= PHASE_ONE_RESET;
            phase_two_reg   <= PHASE_TWO_RESET;
            phase_three_reg <= PHASE_THREE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PHASE_ONE:   phase_one_reg   <= cfg_data[P1_W-1:0];
                CFG_PHASE_TWO:   phase_two_reg   <= cfg_data[P2_W-1:0];
                CFG_PHASE_THREE: phase_three_reg <= cfg_data[P3_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless a finished item is stuck.
    logic advance;
    logic m_valid_reg;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    logic [X_W-1:0] in_x;
    logic [Y_W-1:0] in_y;

    assign in_x = s_tdata[X_W-1:0];
    assign in_y = s_tdata[X_W+Y_W-1:X_W];

    // Stage 1 addresses; sums wrap modulo the ROM depth.
    logic [ADDR_W-1:0] addr_a1;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_c1;
    logic [ADDR_W-1:0] addr_c2;

    assign addr_a1 = ADDR_W'(phase_one_reg) + ADDR_W'(in_x);
    assign addr_b  = ADDR_W'(in_y) + ADDR_W'(phase_two_reg);
    assign addr_c1 = ADDR_W'(in_y) + ADDR_W'(phase_three_reg) + ADDR_W'(in_x);
    assign addr_c2 = ADDR_W'(in_y) + ADDR_W'(phase_one_reg);

    logic [SINE_W-1:0] sine_a1;
    logic [SINE_W-1:0] sine_b;
    logic [SINE_W-1:0] sine_c1;
    logic [SINE_W-1:0] sine_c2;
    logic [SINE_W-1:0] sine_a2;

    ppg_sine_rom u_rom_a1 (
        .aclk (aclk), .sel (SINE_SEL_A), .en (advance), .addr (addr_a1), .data (sine_a1)
    );
    ppg_sine_rom u_rom_b (
        .aclk (aclk), .sel (SINE_SEL_B), .en (advance), .addr (addr_b), .data (sine_b)
    );
    ppg_sine_rom u_rom_c1 (
        .aclk (aclk), .sel (SINE_SEL_C), .en (advance), .addr (addr_c1), .data (sine_c1)
    );
    ppg_sine_rom u_rom_c2 (
        .aclk (aclk), .sel (SINE_SEL_C), .en (advance), .addr (addr_c2), .data (sine_c2)
    );

    // Stage 1 side registers that travel beside the ROM outputs.
    logic           s1_valid_reg;
    logic [X_W-1:0] s1_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_x_reg <= in_x;
        end
    end

    // Stage 2: the nested lookup, addressed by a stage 1 ROM word, and the
    // wrapped sum of the three direct lookups.
    logic [ADDR_W-1:0]  addr_a2;
    logic               s2_valid_reg;
    logic [INDEX_W-1:0] s2_sum_reg;
    logic [INDEX_W-1:0] s2_sum_next;

    assign addr_a2     = ADDR_W'(sine_c2) + ADDR_W'(phase_three_reg) + ADDR_W'(s1_x_reg);
    assign s2_sum_next = INDEX_W'(sine_a1) + INDEX_W'(sine_b) + INDEX_W'(sine_c1);

    ppg_sine_rom u_rom_a2 (
        .aclk (aclk), .sel (SINE_SEL_A), .en (advance), .addr (addr_a2), .data (sine_a2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_sum_reg <= s2_sum_next;
        end
    end

    // Stage 3: final add, palette and the output register.
    logic [INDEX_W-1:0] index_next;
    logic [COLOR_W-1:0] color_next;
    logic [INDEX_W-1:0] m_index_reg;
    logic [COLOR_W-1:0] m_color_reg;

    assign index_next = s2_sum_reg + INDEX_W'(sine_a2);

    ppg_palette u_palette (
        .plasma_index (index_next),
        .pixel_color  (color_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_index_reg <= index_next;
            m_color_reg <= color_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_color_reg, m_index_reg});

endmodule

`default_nettype wire

>>> src/ppg_sine_rom.sv
// Synchronous sine ROM with a registered read; the waveform is picked by a
// tied-off select. Depends on ppg_pkg for the table contents.
`timescale 1ns / 1ps
`default_nettype none

module ppg_sine_rom
    import ppg_pkg::*;
(
    input  wire logic              aclk,
    input  wire sine_sel_t         sel,
    input  wire logic              en,
    input  wire logic [ADDR_W-1:0] addr,
    output logic      [SINE_W-1:0] data
);

    logic [SINE_W-1:0] data_reg;
    logic [SINE_W-1:0] data_next;

    always_comb begin
        case (sel)
            SINE_SEL_A: data_next = SINE_A[addr];
            SINE_SEL_B: data_next = SINE_B[addr];
            SINE_SEL_C: data_next = SINE_C[addr];
            default:    data_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> src/ppg_palette.sv
// Palette: folds the plasma value into a 5-bit level and packs RGB565.
// Depends on ppg_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ppg_palette
    import ppg_pkg::*;
(
    input  wire logic [INDEX_W-1:0] plasma_index,
    output logic      [COLOR_W-1:0] pixel_color
);

    logic [INDEX_W-2:0] folded;
    logic [4:0]         level;
    logic [4:0]         level_inv;

    // Values above 127 fold to 255 - v, which is the bitwise inverse.
    assign folded    = plasma_index[INDEX_W-1] ? ~plasma_index[INDEX_W-2:0]
                                               : plasma_index[INDEX_W-2:0];
    assign level     = folded[INDEX_W-2:2];
    assign level_inv = ~level;   // 31 - level

    // Red in 15:11, green (6 bits, top bit zero) in 10:5, blue in 4:0.
    assign pixel_color = {level, 1'b0, level_inv, level_inv};

endmodule

`default_nettype wire
